[hw/rtl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared widths, reset values and register map of the respiration rate
// detector.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 7;
  localparam int RING_W   = 9;
  localparam int SINCE_W  = 10;
  localparam int BASE_W   = 32;
  localparam int CAL_W    = 16;
  localparam int HYST_W   = 12;
  localparam int IVL_W    = 9;
  localparam int AMP_W    = 16;
  localparam int WIN_W    = 8;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int MIN_HISTORY       = 3;
  localparam int RATE_LOW          = 8;
  localparam int RATE_HIGH         = 80;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CAL_W-1:0]  CAL_RESET     = 16'd2980;
  localparam logic [HYST_W-1:0] HYST_RESET    = 12'd20;
  localparam logic [IVL_W-1:0]  MIN_IVL_RESET = 9'd30;
  localparam logic [IVL_W-1:0]  MAX_IVL_RESET = 9'd400;
  localparam logic [IVL_W-1:0]  TIMEOUT_RESET = 9'd312;
  localparam logic [AMP_W-1:0]  WEAK_RESET    = 16'd50;
  localparam logic [WIN_W-1:0]  WINDOW_RESET  = 8'd125;
  localparam logic [IVL_W-1:0]  STARTUP_RESET = 9'd312;

  localparam logic signed [SAMPLE_W-1:0] WIN_MIN_RESET = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] WIN_MAX_RESET = 16'sh8000;

  typedef enum logic [2:0] {
    REG_CAL     = 3'd0,
    REG_HYST    = 3'd1,
    REG_MIN_IVL = 3'd2,
    REG_MAX_IVL = 3'd3,
    REG_TIMEOUT = 3'd4,
    REG_WEAK    = 3'd5,
    REG_WINDOW  = 3'd6,
    REG_STARTUP = 3'd7
  } reg_idx_t;

endpackage

[hw/rtl/rrd_ram.sv]
// ----------------------------------------------------------------------------
// rrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/rrd_div.sv]
// ----------------------------------------------------------------------------
// rrd_div
// Restoring unsigned divider, one quotient bit per cycle, done pulses for
// one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module rrd_div #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  rem;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        quo   <= num;
        den_r <= den;
        cnt   <= CW'(W - 1);
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/respiration_rate_detector_core.sv]
// ----------------------------------------------------------------------------
// respiration_rate_detector_core
// Averages four samples per request, tracks a baseline, detects breaths by
// hysteresis crossings and derives breaths per minute from an interval ring.
//
//   channel | direction | handshake           | payload
//   in      | in        | in_valid/in_ready   | sample_a..sample_d
//   out     | out       | out_valid/out_ready | breath_rate
//   apb     | in        | psel/penable/pready | paddr, pwdata, prdata
//
// a request passes through S_BASE and S_DET to S_OUT (S_BASE straight to
// S_OUT during startup); when a breath interval completes and at least
// MIN_HISTORY intervals are held, the rate is derived by a ring read sweep
// and two passes through the serial divider
// one request is in work at a time; the next is taken once the result is
// in the output register, even while that result waits for out_ready
// rst is synchronous and restores the core's own registers to their reset values
// ----------------------------------------------------------------------------
module respiration_rate_detector_core #(
  parameter int HISTORY_DEPTH = rrd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rrd_pkg::SAMPLE_W-1:0] sample_a,
  input  logic signed [rrd_pkg::SAMPLE_W-1:0] sample_b,
  input  logic signed [rrd_pkg::SAMPLE_W-1:0] sample_c,
  input  logic signed [rrd_pkg::SAMPLE_W-1:0] sample_d,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rrd_pkg::RATE_W-1:0]          breath_rate,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrd_pkg::ADDR_W-1:0]          paddr,
  input  logic [rrd_pkg::DATA_W-1:0]          pwdata,
  output logic [rrd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  import rrd_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = RING_W + CNT_W;
  localparam int DIV_W = (SUM_W > CAL_W) ? SUM_W : CAL_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_HISTORY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_DET,
    S_SUM,
    S_SUM_END,
    S_AVG_START,
    S_AVG_WAIT,
    S_RATE_START,
    S_RATE_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CAL_W-1:0]  cal;
  logic [HYST_W-1:0] hyst;
  logic [IVL_W-1:0]  min_ivl;
  logic [IVL_W-1:0]  max_ivl;
  logic [IVL_W-1:0]  timeout;
  logic [AMP_W-1:0]  weak_amp;
  logic [WIN_W-1:0]  window;
  logic [IVL_W-1:0]  startup;

  // detector state
  logic signed [BASE_W-1:0]   baseline;
  logic signed [SAMPLE_W-1:0] wave;
  logic signed [SAMPLE_W-1:0] wmin;
  logic signed [SAMPLE_W-1:0] wmax;
  logic [WIN_W-1:0]           wtimer;
  logic [SINCE_W-1:0]         since;
  logic [IDX_W-1:0]           ring_idx;
  logic [CNT_W-1:0]           count;
  logic [IVL_W-1:0]           startup_left;
  logic                       waiting_low;
  logic [RATE_W-1:0]          held;
  logic [HISTORY_DEPTH-1:0]   ring_valid;

  // ring sweep
  logic [IDX_W-1:0] rd_idx;
  logic             acc_en;
  logic             valid_q;
  logic [SUM_W-1:0] total;
  logic [RING_W-1:0] rd_data;
  logic [RING_W-1:0] acc_data;

  // divider
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quo;

  // apb
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_CAL:     prdata = DATA_W'(cal);
      REG_HYST:    prdata = DATA_W'(hyst);
      REG_MIN_IVL: prdata = DATA_W'(min_ivl);
      REG_MAX_IVL: prdata = DATA_W'(max_ivl);
      REG_TIMEOUT: prdata = DATA_W'(timeout);
      REG_WEAK:    prdata = DATA_W'(weak_amp);
      REG_WINDOW:  prdata = DATA_W'(window);
      REG_STARTUP: prdata = DATA_W'(startup);
      default:     prdata = '0;
    endcase
  end

  // four-sample average
  logic [SAMPLE_W+1:0] in_sum;
  assign in_sum = {{2{sample_a[SAMPLE_W-1]}}, sample_a}
                + {{2{sample_b[SAMPLE_W-1]}}, sample_b}
                + {{2{sample_c[SAMPLE_W-1]}}, sample_c}
                + {{2{sample_d[SAMPLE_W-1]}}, sample_d};

  // baseline update with saturation
  logic [BASE_W+1:0]  base_ext;
  logic [BASE_W+1:0]  base_tail;
  logic [BASE_W+1:0]  wave_term;
  logic [BASE_W+1:0]  nb;
  logic [BASE_W-1:0]  base_sat;
  assign base_ext  = {{2{baseline[BASE_W-1]}}, baseline};
  assign base_tail = {{10{baseline[BASE_W-1]}}, baseline[BASE_W-1:8]};
  assign wave_term = {{10{wave[SAMPLE_W-1]}}, wave, 8'b0};
  assign nb        = base_ext - base_tail + wave_term;

  always_comb begin
    if (nb[BASE_W+1:BASE_W-1] == 3'b000 || nb[BASE_W+1:BASE_W-1] == 3'b111) begin
      base_sat = nb[BASE_W-1:0];
    end else if (nb[BASE_W+1]) begin
      base_sat = {1'b1, {(BASE_W-1){1'b0}}};
    end else begin
      base_sat = {1'b0, {(BASE_W-1){1'b1}}};
    end
  end

  // amplitude window
  logic signed [SAMPLE_W-1:0] wmin_n;
  logic signed [SAMPLE_W-1:0] wmax_n;
  logic [WIN_W-1:0]           wtimer_n;
  logic [SAMPLE_W:0]          p2p;
  logic                       win_close;
  logic                       weak_hit;
  assign wmin_n    = (wave < wmin) ? wave : wmin;
  assign wmax_n    = (wave > wmax) ? wave : wmax;
  assign wtimer_n  = wtimer + 1'b1;
  assign p2p       = {wmax_n[SAMPLE_W-1], wmax_n} - {wmin_n[SAMPLE_W-1], wmin_n};
  assign win_close = (wtimer_n >= window);
  assign weak_hit  = (p2p < {1'b0, weak_amp});

  // crossing detector
  logic signed [SAMPLE_W+1:0] wave_x;
  logic signed [SAMPLE_W+1:0] upper;
  logic signed [SAMPLE_W+1:0] lower;
  logic [SAMPLE_W-1:0]        base;
  logic                       go_low;
  logic                       cross_up;
  logic                       in_band;
  logic                       accept_ivl;
  logic [CNT_W-1:0]           count_inc;
  logic [SINCE_W-1:0]         since_det;
  logic                       timeout_hit;

  assign base        = baseline[BASE_W-1:BASE_W-SAMPLE_W];
  assign wave_x      = {{2{wave[SAMPLE_W-1]}}, wave};
  assign upper       = {{2{base[SAMPLE_W-1]}}, base} + (SAMPLE_W+2)'(hyst);
  assign lower       = {{2{base[SAMPLE_W-1]}}, base} - (SAMPLE_W+2)'(hyst);
  assign go_low      = !waiting_low && (wave_x < lower);
  assign cross_up    = waiting_low && (wave_x > upper);
  assign in_band     = (since >= {1'b0, min_ivl}) && (since <= {1'b0, max_ivl});
  assign accept_ivl  = cross_up && in_band;
  assign count_inc   = (count < CNT_FULL) ? count + 1'b1 : count;
  assign since_det   = cross_up ? '0 : since;
  assign timeout_hit = (since_det > {1'b0, timeout});

  assign acc_data = valid_q ? rd_data : '0;

  rrd_ram #(
    .WIDTH (RING_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_DET && accept_ivl),
    .waddr (ring_idx),
    .wdata (since[RING_W-1:0]),
    .re    (state == S_SUM),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign div_start = (state == S_AVG_START) || (state == S_RATE_START);
  assign div_num   = (state == S_AVG_START) ? DIV_W'(total) : DIV_W'(cal);
  assign div_den   = (state == S_AVG_START) ? DIV_W'(count) : div_quo;

  rrd_div #(
    .W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      breath_rate  <= '0;
      cal          <= CAL_RESET;
      hyst         <= HYST_RESET;
      min_ivl      <= MIN_IVL_RESET;
      max_ivl      <= MAX_IVL_RESET;
      timeout      <= TIMEOUT_RESET;
      weak_amp     <= WEAK_RESET;
      window       <= WINDOW_RESET;
      startup      <= STARTUP_RESET;
      baseline     <= '0;
      wave         <= '0;
      wmin         <= WIN_MIN_RESET;
      wmax         <= WIN_MAX_RESET;
      wtimer       <= '0;
      since        <= '0;
      ring_idx     <= '0;
      count        <= '0;
      startup_left <= STARTUP_RESET;
      waiting_low  <= 1'b0;
      held         <= '0;
      ring_valid   <= '0;
      rd_idx       <= '0;
      acc_en       <= 1'b0;
      valid_q      <= 1'b0;
      total        <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      acc_en  <= (state == S_SUM);
      valid_q <= ring_valid[rd_idx];
      if (acc_en) begin
        total <= total + SUM_W'(acc_data);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            wave  <= in_sum[SAMPLE_W+1:2];
            state <= S_BASE;
          end
        end
        S_BASE: begin
          if (startup_left != '0) begin
            startup_left <= startup_left - 1'b1;
            baseline     <= {wave, 16'b0};
            state        <= S_OUT;
          end else begin
            baseline <= base_sat;
            since    <= since + 1'b1;
            if (win_close) begin
              wmin   <= WIN_MIN_RESET;
              wmax   <= WIN_MAX_RESET;
              wtimer <= '0;
              if (weak_hit) begin
                held  <= '0;
                count <= '0;
              end
            end else begin
              wmin   <= wmin_n;
              wmax   <= wmax_n;
              wtimer <= wtimer_n;
            end
            state <= S_DET;
          end
        end
        S_DET: begin
          if (go_low && !timeout_hit) begin
            waiting_low <= 1'b1;
          end
          if (cross_up) begin
            waiting_low <= 1'b0;
            since       <= '0;
            if (in_band) begin
              ring_idx             <= (ring_idx == IDX_LAST) ? '0 : ring_idx + 1'b1;
              ring_valid[ring_idx] <= 1'b1;
              count                <= count_inc;
            end else if (since > {1'b0, max_ivl}) begin
              count <= '0;
            end
          end
          if (timeout_hit) begin
            held        <= '0;
            count       <= '0;
            waiting_low <= 1'b0;
            since       <= '0;
          end
          if (accept_ivl && count_inc >= CNT_MIN) begin
            rd_idx <= '0;
            total  <= '0;
            state  <= S_SUM;
          end else begin
            state <= S_OUT;
          end
        end
        S_SUM: begin
          rd_idx <= rd_idx + 1'b1;
          if (CNT_W'(rd_idx) == count - 1'b1) begin
            state <= S_SUM_END;
          end
        end
        S_SUM_END: begin
          state <= S_AVG_START;
        end
        S_AVG_START: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            state <= (div_quo == '0) ? S_OUT : S_RATE_START;
          end
        end
        S_RATE_START: begin
          state <= S_RATE_WAIT;
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            if (div_quo >= DIV_W'(RATE_LOW) && div_quo <= DIV_W'(RATE_HIGH)) begin
              held <= div_quo[RATE_W-1:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            breath_rate <= held;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_CAL:     cal      <= pwdata[CAL_W-1:0];
          REG_HYST:    hyst     <= pwdata[HYST_W-1:0];
          REG_MIN_IVL: min_ivl  <= pwdata[IVL_W-1:0];
          REG_MAX_IVL: max_ivl  <= pwdata[IVL_W-1:0];
          REG_TIMEOUT: timeout  <= pwdata[IVL_W-1:0];
          REG_WEAK:    weak_amp <= pwdata[AMP_W-1:0];
          REG_WINDOW:  window   <= pwdata[WIN_W-1:0];
          REG_STARTUP: begin
            startup      <= pwdata[IVL_W-1:0];
            startup_left <= pwdata[IVL_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[hw/rtl/rrd_checker.sv]
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks of the respiration rate detector, bound to respiration_rate_detector_core.
// ----------------------------------------------------------------------------
module rrd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rrd_pkg::RATE_W-1:0] breath_rate,
  input logic                       pready
);

  import rrd_pkg::*;

  // rate is unknown or inside the accepted band
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (breath_rate == '0 ||
                   (breath_rate >= RATE_W'(RATE_LOW) && breath_rate <= RATE_W'(RATE_HIGH))))
    else $error("breath_rate outside the valid band");

  // one request in work at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(breath_rate)))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind respiration_rate_detector_core rrd_checker u_rrd_checker (.*);
